/* design/gqi_pkg.sv */
// Shared types and constants for the gyro quaternion integrator.
package gqi_pkg;

  localparam int unsigned RateW = 24;
  localparam int unsigned QuatW = 32;
  localparam int unsigned StepW = 16;
  localparam logic [StepW-1:0] StepReset = 16'd3277;

  // Datapath commands issued by the controller.
  typedef struct packed {
    logic load;      // capture sample, remap, start step
    logic prod;      // at most one quaternion-rate product per cycle
    logic scale;     // rounding and time step multiply per component
    logic norm_prep; // block scale search
    logic sq;        // one square per cycle
    logic sqrt_step; // one root iteration
    logic norm_fix;  // clamp norm
    logic div_step;  // one quotient bit
    logic commit;    // write quaternion, present result
  } gqi_cmd_t;

  typedef struct packed {
    logic done;      // current phase finished
  } gqi_sts_t;

endpackage

/* design/gqi_ctrl.sv */
// Sequencer for one integration step.
module gqi_ctrl
  import gqi_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  gqi_sts_t sts_i,
  output gqi_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_PROD, S_SCALE, S_PREP, S_SQ, S_SQRT, S_FIX, S_DIV, S_COMMIT
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  // a new transaction may enter while the old result waits, once idle
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load      = (state_q == S_IDLE) && in_valid_i;
    cmd_o.prod      = (state_q == S_PROD);
    cmd_o.scale     = (state_q == S_SCALE);
    cmd_o.norm_prep = (state_q == S_PREP);
    cmd_o.sq        = (state_q == S_SQ);
    cmd_o.sqrt_step = (state_q == S_SQRT);
    cmd_o.norm_fix  = (state_q == S_FIX);
    cmd_o.div_step  = (state_q == S_DIV);
    cmd_o.commit    = (state_q == S_COMMIT) && !(out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // a commit refills the result register in the cycle the old one leaves
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE:   if (in_valid_i) state_q <= S_PROD;
        S_PROD:   if (sts_i.done) state_q <= S_SCALE;
        S_SCALE:  if (sts_i.done) state_q <= S_PREP;
        S_PREP:   state_q <= S_SQ;
        S_SQ:     if (sts_i.done) state_q <= S_SQRT;
        S_SQRT:   if (sts_i.done) state_q <= S_FIX;
        S_FIX:    state_q <= S_DIV;
        S_DIV:    if (sts_i.done) state_q <= S_COMMIT;
        S_COMMIT: if (cmd_o.commit) state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* design/gqi_dp.sv */
// Datapath: remap, quaternion rate product, normalization.
module gqi_dp
  import gqi_pkg::*;
#(
  parameter int unsigned QuatFracBits = 30
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  gqi_cmd_t                cmd_i,
  output gqi_sts_t                sts_o,
  input  logic        [StepW-1:0] time_step_i,
  input  logic signed [RateW-1:0] gyro_sensor_x_i,
  input  logic signed [RateW-1:0] gyro_sensor_y_i,
  input  logic signed [RateW-1:0] gyro_sensor_z_i,
  input  logic signed [RateW-1:0] accel_sensor_x_i,
  input  logic signed [RateW-1:0] accel_sensor_y_i,
  input  logic signed [RateW-1:0] accel_sensor_z_i,
  output logic signed [RateW-1:0] gyro_body_x_o,
  output logic signed [RateW-1:0] gyro_body_y_o,
  output logic signed [RateW-1:0] gyro_body_z_o,
  output logic signed [RateW-1:0] accel_body_x_o,
  output logic signed [RateW-1:0] accel_body_y_o,
  output logic signed [RateW-1:0] accel_body_z_o,
  output logic signed [QuatW-1:0] quat_w_o,
  output logic signed [QuatW-1:0] quat_x_o,
  output logic signed [QuatW-1:0] quat_y_o,
  output logic signed [QuatW-1:0] quat_z_o
);

  localparam logic signed [QuatW-1:0] QuatOne = QuatW'(64'd1 << QuatFracBits);
  localparam int unsigned SumW = 60;   // exact sum of three 32x24 products
  localparam int unsigned NW   = 40;   // q + d fits easily
  localparam int unsigned SsW  = 64;
  localparam int unsigned QW   = 64;   // quotient width before saturation

  function automatic logic signed [RateW-1:0] neg_sat(logic signed [RateW-1:0] v);
    if (v == {1'b1, {(RateW-1){1'b0}}}) return {1'b0, {(RateW-1){1'b1}}};
    return -v;
  endfunction

  logic signed [RateW-1:0] g_q [3];
  logic signed [RateW-1:0] a_q [3];
  logic signed [QuatW-1:0] q_q [4];
  logic signed [QuatW-1:0] qo_q [4];
  logic signed [SumW-1:0]  s_q [4];
  logic signed [NW-1:0]    n_q [4];
  logic signed [QuatW-1:0] m_q [4];
  logic [3:0]              cnt_q;
  logic [5:0]              k_q;
  logic [SsW-1:0]          ss_q, rem_q, res_q, bit_q;
  logic [QuatW-1:0]        nrm_q;
  logic [QuatW+1:0]        drem_q;  // partial remainder, always below 2N
  logic [QW-1:0]           dquo_q;  // dividend bits out, quotient bits in
  logic [6:0]              dcnt_q;

  // product term selection: 12 terms, S_i += sign * q_j * g_l
  logic [1:0]              t_row;
  logic [1:0]              t_qi;
  logic [1:0]              t_gi;
  logic                    t_neg;
  always_comb begin
    t_row = cnt_q[3:2];
    t_qi  = '0; t_gi = '0; t_neg = 1'b0;
    unique case (cnt_q)
      4'd0:  begin t_qi = 2'd1; t_gi = 2'd0; t_neg = 1'b1; end
      4'd1:  begin t_qi = 2'd2; t_gi = 2'd1; t_neg = 1'b1; end
      4'd2:  begin t_qi = 2'd3; t_gi = 2'd2; t_neg = 1'b1; end
      4'd4:  begin t_qi = 2'd0; t_gi = 2'd0; end
      4'd5:  begin t_qi = 2'd2; t_gi = 2'd2; end
      4'd6:  begin t_qi = 2'd3; t_gi = 2'd1; t_neg = 1'b1; end
      4'd8:  begin t_qi = 2'd0; t_gi = 2'd1; end
      4'd9:  begin t_qi = 2'd1; t_gi = 2'd2; t_neg = 1'b1; end
      4'd10: begin t_qi = 2'd3; t_gi = 2'd0; end
      4'd12: begin t_qi = 2'd0; t_gi = 2'd2; end
      4'd13: begin t_qi = 2'd1; t_gi = 2'd1; end
      4'd14: begin t_qi = 2'd2; t_gi = 2'd0; t_neg = 1'b1; end
      default: ;
    endcase
  end

  logic signed [QuatW+RateW-1:0] prod;
  assign prod = q_q[t_qi] * g_q[t_gi];

  // scaling of one component
  logic signed [SumW-1:0]  t_full;
  logic signed [SumW-16:0] t_r;
  logic signed [SumW+1:0]  td;
  logic signed [NW-1:0]    d_r;
  assign t_full = s_q[cnt_q[1:0]] + SumW'(33'sd32768);
  assign t_r    = (SumW-15)'(t_full >>> 16);
  assign td     = t_r * $signed({1'b0, time_step_i}) + 62'sd65536;
  assign d_r    = NW'(td >>> 17);

  // block scale
  logic [NW-1:0] mx;
  always_comb begin
    mx = '0;
    for (int i = 0; i < 4; i++) begin
      logic [NW-1:0] av;
      av = n_q[i][NW-1] ? NW'(-n_q[i]) : NW'(n_q[i]);
      if (av > mx) mx = av;
    end
  end
  logic [5:0] k_c;
  always_comb begin
    k_c = '0;
    for (int b = 31; b < NW; b++) if (mx[b]) k_c = 6'(b - 30);
  end

  logic signed [2*QuatW-1:0] msq;
  assign msq = m_q[cnt_q[1:0]] * m_q[cnt_q[1:0]];

  // division, one quotient bit per cycle
  logic [QuatW-1:0] am;
  assign am = m_q[cnt_q[1:0]][QuatW-1] ? QuatW'(-m_q[cnt_q[1:0]])
                                       : QuatW'(m_q[cnt_q[1:0]]);
  logic [QuatW+1:0] two_n;
  logic [QuatW+1:0] rem_n;
  logic             q_bit;
  logic [QW-1:0]    quo_n;
  assign two_n = {1'b0, nrm_q, 1'b0};
  assign rem_n = {drem_q[QuatW:0], dquo_q[QW-1]};
  assign q_bit = (rem_n >= two_n);
  assign quo_n = {dquo_q[QW-2:0], q_bit};

  logic signed [QuatW-1:0] qsat;
  always_comb begin
    logic signed [QW+1:0] v;
    v = m_q[cnt_q[1:0]][QuatW-1] ? -$signed({2'b0, quo_n}) : $signed({2'b0, quo_n});
    if (v > 66'sd2147483647) qsat = 32'sh7fffffff;
    else if (v < -66'sd2147483648) qsat = 32'sh80000000;
    else qsat = QuatW'(v);
  end

  logic done;
  assign sts_o.done = done;
  always_comb begin
    done = 1'b0;
    if (cmd_i.prod)      done = (cnt_q == 4'd14);
    if (cmd_i.scale)     done = (cnt_q == 4'd3);
    if (cmd_i.sq)        done = (cnt_q == 4'd3);
    if (cmd_i.sqrt_step) done = (bit_q == 64'd1);
    if (cmd_i.div_step)  done = (cnt_q == 4'd3) && (dcnt_q == 7'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q[0] <= QuatOne;
      q_q[1] <= '0;
      q_q[2] <= '0;
      q_q[3] <= '0;
      cnt_q  <= '0;
      dcnt_q <= '0;
    end else begin
      if (cmd_i.load) begin
        g_q[0] <= gyro_sensor_z_i;
        g_q[1] <= neg_sat(gyro_sensor_x_i);
        g_q[2] <= neg_sat(gyro_sensor_y_i);
        a_q[0] <= accel_sensor_z_i;
        a_q[1] <= neg_sat(accel_sensor_x_i);
        a_q[2] <= neg_sat(accel_sensor_y_i);
        for (int i = 0; i < 4; i++) s_q[i] <= '0;
        cnt_q <= '0;
      end
      if (cmd_i.prod) begin
        if (cnt_q[1:0] != 2'd3)
          s_q[t_row] <= t_neg ? s_q[t_row] - SumW'(prod) : s_q[t_row] + SumW'(prod);
        cnt_q <= done ? 4'd0 : cnt_q + 4'd1;
      end
      if (cmd_i.scale) begin
        n_q[cnt_q[1:0]] <= NW'(q_q[cnt_q[1:0]]) + d_r;
        cnt_q <= done ? 4'd0 : cnt_q + 4'd1;
      end
      if (cmd_i.norm_prep) begin
        k_q <= k_c;
        for (int i = 0; i < 4; i++) m_q[i] <= QuatW'(n_q[i] >>> k_c);
        ss_q <= '0;
        cnt_q <= '0;
      end
      if (cmd_i.sq) begin
        ss_q <= ss_q + SsW'(msq);
        if (done) begin
          rem_q <= ss_q + SsW'(msq);
          res_q <= '0;
          bit_q <= 64'd1 << 62;
        end
        cnt_q <= done ? 4'd0 : cnt_q + 4'd1;
      end
      if (cmd_i.sqrt_step) begin
        if (rem_q >= res_q + bit_q) begin
          rem_q <= rem_q - (res_q + bit_q);
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      if (cmd_i.norm_fix) begin
        nrm_q <= (k_q == '0 && res_q[QuatW-1:0] < QuatW'(QuatOne))
                 ? QuatW'(QuatOne) : res_q[QuatW-1:0];
        cnt_q  <= '0;
        dcnt_q <= '0;
      end
      if (cmd_i.div_step) begin
        // restoring divide of (2*a*2^F + N) by 2N, one bit a cycle
        if (dcnt_q == 7'd0) begin
          drem_q <= '0;
          dquo_q <= (QW'(am) << (QuatFracBits + 1)) + QW'(nrm_q);
          dcnt_q <= 7'(QW);
        end else begin
          drem_q <= q_bit ? rem_n - two_n : rem_n;
          dquo_q <= quo_n;
          dcnt_q <= dcnt_q - 7'd1;
          if (dcnt_q == 7'd1) begin
            qo_q[cnt_q[1:0]] <= qsat;
            cnt_q <= cnt_q + 4'd1;
          end
        end
      end
      if (cmd_i.commit) begin
        for (int i = 0; i < 4; i++) q_q[i] <= qo_q[i];
        gyro_body_x_o  <= g_q[0];
        gyro_body_y_o  <= g_q[1];
        gyro_body_z_o  <= g_q[2];
        accel_body_x_o <= a_q[0];
        accel_body_y_o <= a_q[1];
        accel_body_z_o <= a_q[2];
        quat_w_o <= qo_q[0];
        quat_x_o <= qo_q[1];
        quat_y_o <= qo_q[2];
        quat_z_o <= qo_q[3];
      end
    end
  end

endmodule

/* design/gyro_quaternion_integrator_top.sv */
// Gyro quaternion integrator: sequencer, datapath and time step register.
// Sequence per sample: product slots, one scaling per component, a block scale, one
//   square per component, the root steps, a clamp, a serial quotient bit divide per
//   component and a commit.
// A new sample is accepted only in idle, once the previous step has committed.
// Reset: quaternion returns to (1, 0, 0, 0), time step to 3277 (0.05 s).
// The result register holds until taken; the next sample enters meanwhile.
module gyro_quaternion_integrator_top
  import gqi_pkg::*;
#(
  parameter int unsigned QUAT_FRAC_BITS = 30
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [1:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [RateW-1:0] gyro_sensor_x_i,
  input  logic signed [RateW-1:0] gyro_sensor_y_i,
  input  logic signed [RateW-1:0] gyro_sensor_z_i,
  input  logic signed [RateW-1:0] accel_sensor_x_i,
  input  logic signed [RateW-1:0] accel_sensor_y_i,
  input  logic signed [RateW-1:0] accel_sensor_z_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [RateW-1:0] gyro_body_x_o,
  output logic signed [RateW-1:0] gyro_body_y_o,
  output logic signed [RateW-1:0] gyro_body_z_o,
  output logic signed [RateW-1:0] accel_body_x_o,
  output logic signed [RateW-1:0] accel_body_y_o,
  output logic signed [RateW-1:0] accel_body_z_o,
  output logic signed [QuatW-1:0] quat_w_o,
  output logic signed [QuatW-1:0] quat_x_o,
  output logic signed [QuatW-1:0] quat_y_o,
  output logic signed [QuatW-1:0] quat_z_o
);

  localparam logic [1:0] AddrTimeStep = 2'd0;

  logic [StepW-1:0] time_step_q;
  gqi_cmd_t cmd;
  gqi_sts_t sts;

  assign pready = 1'b1;
  // only one register; other addresses read zero
  assign prdata = (paddr == AddrTimeStep) ? {16'd0, time_step_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= StepReset;
    end else if (psel && penable && pwrite && paddr == AddrTimeStep) begin
      time_step_q <= pwdata[StepW-1:0];
    end
  end

  gqi_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  gqi_dp #(.QuatFracBits(QUAT_FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .time_step_i(time_step_q),
    .gyro_sensor_x_i, .gyro_sensor_y_i, .gyro_sensor_z_i,
    .accel_sensor_x_i, .accel_sensor_y_i, .accel_sensor_z_i,
    .gyro_body_x_o, .gyro_body_y_o, .gyro_body_z_o,
    .accel_body_x_o, .accel_body_y_o, .accel_body_z_o,
    .quat_w_o, .quat_x_o, .quat_y_o, .quat_z_o
  );

endmodule
